// ----- rtl/cgmf_pkg.sv -----
package cgmf_pkg;

  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;
  localparam int LOCAL_SIZE_DEF  = 256;
  localparam int FIFO_DEPTH_DEF  = 16;

  localparam logic [7:0] UNKNOWN_COST = 8'hFF;

  localparam logic signed [15:0] POSE_COS_RST   = 16'sd16384;
  localparam logic [23:0]        CELL_SIZE_RST  = 24'd6554;
  localparam logic [23:0]        CELLS_PER_M_RST = 24'd655360;

  localparam logic [1:0] REG_GRID_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_GRID_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_CELLS_PER_M   = 2'd2;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_CELL  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_CELL = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       hit;
    logic [7:0] col8;
    logic [7:0] row8;
    logic [7:0] cost;
  } cmd_meta_t;

endpackage

// ----- rtl/cgmf_front.sv -----
module cgmf_front #(
  parameter int GRID_WIDTH  = cgmf_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = cgmf_pkg::GRID_HEIGHT_DEF,
  parameter int LOCAL_SIZE  = cgmf_pkg::LOCAL_SIZE_DEF,
  parameter int FIFO_DEPTH  = cgmf_pkg::FIFO_DEPTH_DEF,
  parameter int AW          = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic [7:0]               in_cell_x,
  input  logic [7:0]               in_cell_y,
  input  logic [7:0]               in_cost,
  input  logic signed [31:0]       in_robot_x,
  input  logic signed [31:0]       in_robot_y,
  input  logic signed [15:0]       in_cos_yaw,
  input  logic signed [15:0]       in_sin_yaw,
  input  logic signed [31:0]       in_local_origin_x,
  input  logic signed [31:0]       in_local_origin_y,
  input  logic [23:0]              in_local_cell_size,
  input  logic signed [31:0]       grid_origin_x,
  input  logic signed [31:0]       grid_origin_y,
  input  logic [23:0]              grid_cells_per_meter,
  input  logic                     back_ready,
  input  logic                     q_pop,
  output logic                     q_push,
  output cgmf_pkg::cmd_meta_t      q_push_meta,
  output logic [AW-1:0]            q_push_addr
);
  import cgmf_pkg::*;

  localparam int CW   = $clog2(GRID_WIDTH);
  localparam int RW   = $clog2(GRID_HEIGHT);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);
  localparam int NSTG = 6;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] cost;
  } stg_meta_t;

  logic                    accept;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [NSTG-1:0]         vld_r;

  logic signed [31:0]      pose_x_r, pose_y_r;
  logic signed [15:0]      pose_cos_r, pose_sin_r;
  logic signed [31:0]      org_x_r, org_y_r;
  logic [23:0]             csize_r;

  stg_meta_t               meta_nxt;
  stg_meta_t               meta_r [NSTG-1];

  logic [32:0]             twice_x, twice_y;
  logic signed [33:0]      lx_nxt, ly_nxt, lx_r, ly_r;
  logic signed [49:0]      m1_r, m2_r, m3_r, m4_r;
  logic signed [50:0]      sx, sy;
  logic signed [38:0]      dx_nxt, dy_nxt, dx_r, dy_r;
  logic [43:0]             plo_x_r, plo_y_r;
  logic signed [43:0]      phi_x_r, phi_y_r;
  logic signed [63:0]      px_r, py_r;
  logic [31:0]             qx, qy;
  logic                    x_in, y_in, rx_in, ry_in;

  cmd_meta_t               cmd_nxt, cmd_r;
  logic [CW-1:0]           col_nxt, col_r;
  logic [RW-1:0]           row_nxt, row_r;

  // credits cover every item between the input and the queue output
  assign in_stall = !back_ready || (cnt_r == CNTW'(FIFO_DEPTH)) ||
                    ((in_opcode == OP_FRAME) && (|vld_r));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cnt_nxt = cnt_r + CNTW'(accept) - CNTW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= {vld_r[NSTG-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r   <= '0;
      pose_y_r   <= '0;
      pose_cos_r <= POSE_COS_RST;
      pose_sin_r <= '0;
      org_x_r    <= '0;
      org_y_r    <= '0;
      csize_r    <= CELL_SIZE_RST;
    end else if (accept && (in_opcode == OP_FRAME)) begin
      pose_x_r   <= in_robot_x;
      pose_y_r   <= in_robot_y;
      pose_cos_r <= in_cos_yaw;
      pose_sin_r <= in_sin_yaw;
      org_x_r    <= in_local_origin_x;
      org_y_r    <= in_local_origin_y;
      csize_r    <= in_local_cell_size;
    end
  end

  always_comb begin
    meta_nxt.cx   = in_cell_x;
    meta_nxt.cy   = in_cell_y;
    meta_nxt.cost = in_cost;
    case (in_opcode)
      OP_CELL: begin
        if ((in_cost == UNKNOWN_COST) || (32'(in_cell_x) >= 32'(LOCAL_SIZE)) ||
            (32'(in_cell_y) >= 32'(LOCAL_SIZE))) begin
          meta_nxt.kind = CMD_NONE;
        end else begin
          meta_nxt.kind = CMD_CELL;
        end
      end
      OP_READ: meta_nxt.kind = CMD_READ;
      default: meta_nxt.kind = CMD_NONE;
    endcase
  end

  // cell center in the local frame
  always_comb begin
    twice_x = 33'({in_cell_x, 1'b1}) * 33'(csize_r);
    twice_y = 33'({in_cell_y, 1'b1}) * 33'(csize_r);
    lx_nxt  = 34'(org_x_r) + $signed({2'b00, twice_x[32:1]});
    ly_nxt  = 34'(org_y_r) + $signed({2'b00, twice_y[32:1]});
  end

  // rotate, translate, offset from grid origin
  always_comb begin
    sx     = 51'(m1_r) - 51'(m2_r);
    sy     = 51'(m3_r) + 51'(m4_r);
    dx_nxt = 39'(pose_x_r) + 39'($signed(sx[50:14])) - 39'(grid_origin_x);
    dy_nxt = 39'(pose_y_r) + 39'($signed(sy[50:14])) - 39'(grid_origin_y);
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= meta_nxt;
    for (int i = 1; i < NSTG - 1; i++) begin
      meta_r[i] <= meta_r[i-1];
    end
    lx_r    <= lx_nxt;
    ly_r    <= ly_nxt;
    m1_r    <= 50'(lx_r) * 50'(pose_cos_r);
    m2_r    <= 50'(ly_r) * 50'(pose_sin_r);
    m3_r    <= 50'(lx_r) * 50'(pose_sin_r);
    m4_r    <= 50'(ly_r) * 50'(pose_cos_r);
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    plo_x_r <= 44'(dx_r[19:0]) * 44'(grid_cells_per_meter);
    plo_y_r <= 44'(dy_r[19:0]) * 44'(grid_cells_per_meter);
    phi_x_r <= 44'($signed(dx_r[38:20])) * 44'($signed({1'b0, grid_cells_per_meter}));
    phi_y_r <= 44'($signed(dy_r[38:20])) * 44'($signed({1'b0, grid_cells_per_meter}));
    px_r    <= (64'(phi_x_r) <<< 20) + $signed({20'b0, plo_x_r});
    py_r    <= (64'(phi_y_r) <<< 20) + $signed({20'b0, plo_y_r});
    cmd_r   <= cmd_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
  end

  // truncate toward zero, then grid bounds
  always_comb begin
    qx    = px_r[63:32] + {31'b0, px_r[63] & (|px_r[31:0])};
    qy    = py_r[63:32] + {31'b0, py_r[63] & (|py_r[31:0])};
    x_in  = !qx[31] && (qx < 32'(GRID_WIDTH));
    y_in  = !qy[31] && (qy < 32'(GRID_HEIGHT));
    rx_in = 32'(meta_r[NSTG-2].cx) < 32'(GRID_WIDTH);
    ry_in = 32'(meta_r[NSTG-2].cy) < 32'(GRID_HEIGHT);

    cmd_nxt = '{kind: CMD_NONE, hit: 1'b0, col8: 8'd0, row8: 8'd0, cost: 8'd0};
    col_nxt = '0;
    row_nxt = '0;
    case (meta_r[NSTG-2].kind)
      CMD_CELL: begin
        if (x_in && y_in) begin
          cmd_nxt.kind = CMD_CELL;
          cmd_nxt.hit  = 1'b1;
          cmd_nxt.col8 = qx[7:0];
          cmd_nxt.row8 = qy[7:0];
          cmd_nxt.cost = meta_r[NSTG-2].cost;
          col_nxt      = qx[CW-1:0];
          row_nxt      = qy[RW-1:0];
        end
      end
      CMD_READ: begin
        cmd_nxt.kind = CMD_READ;
        cmd_nxt.hit  = rx_in && ry_in;
        cmd_nxt.col8 = meta_r[NSTG-2].cx;
        cmd_nxt.row8 = meta_r[NSTG-2].cy;
        if (rx_in && ry_in) begin
          col_nxt = CW'(meta_r[NSTG-2].cx);
          row_nxt = RW'(meta_r[NSTG-2].cy);
        end
      end
      default: ;
    endcase
  end

  assign q_push      = vld_r[NSTG-1];
  assign q_push_meta = cmd_r;
  assign q_push_addr = AW'(32'(row_r) * 32'(GRID_WIDTH) + 32'(col_r));

endmodule

// ----- rtl/cgmf_fifo.sv -----
module cgmf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cgmf_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);
  import cgmf_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_pop;

  assign do_pop  = pop && !empty;
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNTW'(DEPTH));
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CNTW'(push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/cgmf_back.sv -----
module cgmf_back #(
  parameter int GRID_DEPTH = cgmf_pkg::GRID_WIDTH_DEF * cgmf_pkg::GRID_HEIGHT_DEF,
  parameter int AW         = $clog2(GRID_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cgmf_pkg::cmd_meta_t q_meta,
  input  logic [AW-1:0]       q_addr,
  output logic                q_pop,
  output logic                back_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_entry_value,
  output logic                out_entry_updated,
  output logic [7:0]          out_grid_col,
  output logic [7:0]          out_grid_row
);
  import cgmf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RMW   = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [7:0]      grid_mem [GRID_DEPTH];
  logic [7:0]      rdata_r;
  logic            rd_en, wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  cmd_meta_t       cmd_r;
  logic [AW-1:0]   addr_r;
  logic            slot_free, load;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      res_value;
  logic            res_updated;
  logic [7:0]      res_col, res_row;
  logic [7:0]      val_r, col_r, row_r;
  logic            upd_r;

  assign slot_free  = !out_valid_r || !out_stall;
  assign back_ready = (state_r != ST_CLEAR);

  always_comb begin
    res_value   = 8'd0;
    res_updated = 1'b0;
    res_col     = 8'd0;
    res_row     = 8'd0;
    case (cmd_r.kind)
      CMD_CELL: begin
        res_value   = ((rdata_r == UNKNOWN_COST) || (cmd_r.cost > rdata_r)) ?
                      cmd_r.cost : rdata_r;
        res_updated = 1'b1;
        res_col     = cmd_r.col8;
        res_row     = cmd_r.row8;
      end
      CMD_READ: begin
        res_value = cmd_r.hit ? rdata_r : UNKNOWN_COST;
        res_col   = cmd_r.col8;
        res_row   = cmd_r.row8;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = clr_cnt_r;
    wr_data     = UNKNOWN_COST;
    load        = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(GRID_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          if (cmd_r.kind == CMD_CELL) begin
            wr_en   = 1'b1;
            wr_addr = addr_r;
            wr_data = res_value;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= grid_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_meta;
      addr_r <= q_addr;
    end
    if (load) begin
      val_r <= res_value;
      upd_r <= res_updated;
      col_r <= res_col;
      row_r <= res_row;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_value   = val_r;
  assign out_entry_updated = upd_r;
  assign out_grid_col      = col_r;
  assign out_grid_row      = row_r;

endmodule

// ----- rtl/costmap_to_grid_max_fusion_core.sv -----
// Flow: each item is a read-modify-write on the grid memory: it is read in the
// idle state and written back in the read-modify-write state once the result
// slot is free, and no new item is popped before that. A frame item waits until
// the 6-stage transform pipeline has drained.
// Reset: synchronous, active low; the grid is then cleared to unknown one entry
// per cycle while inputs stall; APB stays open.
module costmap_to_grid_max_fusion_core #(
  parameter int GRID_WIDTH  = cgmf_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = cgmf_pkg::GRID_HEIGHT_DEF,
  parameter int LOCAL_SIZE  = cgmf_pkg::LOCAL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic [7:0]         in_cost,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [15:0] in_cos_yaw,
  input  logic signed [15:0] in_sin_yaw,
  input  logic signed [31:0] in_local_origin_x,
  input  logic signed [31:0] in_local_origin_y,
  input  logic [23:0]        in_local_cell_size,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_entry_value,
  output logic               out_entry_updated,
  output logic [7:0]         out_grid_col,
  output logic [7:0]         out_grid_row
);
  import cgmf_pkg::*;

  localparam int GRID_DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int MW         = $bits(cmd_meta_t);
  localparam int QW         = MW + AW;

  logic signed [31:0] grid_origin_x_r, grid_origin_y_r;
  logic [23:0]        cells_per_m_r;

  logic               q_push, q_pop, q_empty, q_full, back_ready;
  cmd_meta_t          push_meta, pop_meta;
  logic [AW-1:0]      push_addr, pop_addr;
  logic [QW-1:0]      q_rd_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_origin_x_r <= '0;
      grid_origin_y_r <= '0;
      cells_per_m_r   <= CELLS_PER_M_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GRID_ORIGIN_X: grid_origin_x_r <= pwdata;
        REG_GRID_ORIGIN_Y: grid_origin_y_r <= pwdata;
        REG_CELLS_PER_M:   cells_per_m_r   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_ORIGIN_X: prdata = grid_origin_x_r;
      REG_GRID_ORIGIN_Y: prdata = grid_origin_y_r;
      REG_CELLS_PER_M:   prdata = {8'd0, cells_per_m_r};
      default:           prdata = 32'd0;
    endcase
  end

  cgmf_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .LOCAL_SIZE  (LOCAL_SIZE),
    .FIFO_DEPTH  (FIFO_DEPTH_DEF),
    .AW          (AW)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_cell_x            (in_cell_x),
    .in_cell_y            (in_cell_y),
    .in_cost              (in_cost),
    .in_robot_x           (in_robot_x),
    .in_robot_y           (in_robot_y),
    .in_cos_yaw           (in_cos_yaw),
    .in_sin_yaw           (in_sin_yaw),
    .in_local_origin_x    (in_local_origin_x),
    .in_local_origin_y    (in_local_origin_y),
    .in_local_cell_size   (in_local_cell_size),
    .grid_origin_x        (grid_origin_x_r),
    .grid_origin_y        (grid_origin_y_r),
    .grid_cells_per_meter (cells_per_m_r),
    .back_ready           (back_ready),
    .q_pop                (q_pop),
    .q_push               (q_push),
    .q_push_meta          (push_meta),
    .q_push_addr          (push_addr)
  );

  cgmf_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({push_meta, push_addr}),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .full    (q_full)
  );

  assign pop_meta = cmd_meta_t'(q_rd_data[QW-1:AW]);
  assign pop_addr = q_rd_data[AW-1:0];

  cgmf_back #(
    .GRID_DEPTH (GRID_DEPTH),
    .AW         (AW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_meta            (pop_meta),
    .q_addr            (pop_addr),
    .q_pop             (q_pop),
    .back_ready        (back_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_value   (out_entry_value),
    .out_entry_updated (out_entry_updated),
    .out_grid_col      (out_grid_col),
    .out_grid_row      (out_grid_row)
  );

`ifndef NO_ASSERTIONS
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !back_ready |-> q_empty)
    else $error("queued transaction during grid clear");

  a_update_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_updated) |-> (out_entry_value != UNKNOWN_COST))
    else $error("updated entry left unknown");
`endif

endmodule

// ----- tb/sv/costmap_to_grid_max_fusion_core_test.sv -----
module costmap_to_grid_max_fusion_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cgmf_pkg::*;

  localparam int GRID_W = GRID_WIDTH_DEF;
  localparam int GRID_H = GRID_HEIGHT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 155;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 300000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
    logic [7:0]         cost;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [31:0] local_origin_x;
    logic signed [31:0] local_origin_y;
    logic [23:0]        local_cell_size;
  } fuse_req_t;

  localparam int REQ_W = $bits(fuse_req_t);

  typedef struct packed {
    logic [7:0] value;
    logic       updated;
    logic [7:0] col;
    logic [7:0] row;
  } fuse_res_t;

  typedef struct packed {
    fuse_req_t req;
    logic      typed;
    fuse_res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [1:0] in_opcode;
  logic [7:0] in_cell_x, in_cell_y, in_cost;
  logic signed [31:0] in_robot_x, in_robot_y;
  logic signed [15:0] in_cos_yaw, in_sin_yaw;
  logic signed [31:0] in_local_origin_x, in_local_origin_y;
  logic [23:0] in_local_cell_size;
  logic out_valid, out_stall;
  logic [7:0] out_entry_value;
  logic out_entry_updated;
  logic [7:0] out_grid_col, out_grid_row;

  costmap_to_grid_max_fusion_core uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_cost(in_cost), .in_robot_x(in_robot_x), .in_robot_y(in_robot_y),
    .in_cos_yaw(in_cos_yaw), .in_sin_yaw(in_sin_yaw),
    .in_local_origin_x(in_local_origin_x), .in_local_origin_y(in_local_origin_y),
    .in_local_cell_size(in_local_cell_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_value(out_entry_value), .out_entry_updated(out_entry_updated),
    .out_grid_col(out_grid_col), .out_grid_row(out_grid_row)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's state
  logic [7:0] grid_img [GRID_W*GRID_H];
  longint pose_x, pose_y, pose_c, pose_s;
  longint fr_ox, fr_oy, fr_cs;
  longint g_ox, g_oy, g_cpm;
  logic [15:0] recent_hits [$];

  fuse_res_t pending_entries [$];
  int mismatch_count = 0;
  int src_idle = 0;
  int sink_idle = 0;
  bit hold_req = 1'b0;
  dir_row_t dir_rows [$];

  function automatic longint trunc_shift32(input longint v);
    if (v < 0) return -((-v) >>> 32);
    return v >>> 32;
  endfunction

  function automatic fuse_res_t fuse_cell(input fuse_req_t r);
    fuse_res_t res;
    longint lx, ly, wx, wy, col, row;
    int idx;
    res = '0;
    if (r.opcode == OP_FRAME) begin
      pose_x = $signed(r.robot_x);
      pose_y = $signed(r.robot_y);
      pose_c = $signed(r.cos_yaw);
      pose_s = $signed(r.sin_yaw);
      fr_ox = $signed(r.local_origin_x);
      fr_oy = $signed(r.local_origin_y);
      fr_cs = longint'(r.local_cell_size);
    end else if (r.opcode == OP_CELL && r.cost != UNKNOWN_COST) begin
      lx = fr_ox + (((2 * longint'(r.cell_x) + 1) * fr_cs) >>> 1);
      ly = fr_oy + (((2 * longint'(r.cell_y) + 1) * fr_cs) >>> 1);
      wx = pose_x + ((lx * pose_c - ly * pose_s) >>> 14);
      wy = pose_y + ((lx * pose_s + ly * pose_c) >>> 14);
      col = trunc_shift32((wx - g_ox) * g_cpm);
      row = trunc_shift32((wy - g_oy) * g_cpm);
      if (col >= 0 && col < GRID_W && row >= 0 && row < GRID_H) begin
        idx = int'(row) * GRID_W + int'(col);
        if (grid_img[idx] == UNKNOWN_COST || r.cost > grid_img[idx]) grid_img[idx] = r.cost;
        res.value = grid_img[idx];
        res.updated = 1'b1;
        res.col = col[7:0];
        res.row = row[7:0];
        recent_hits = {recent_hits, {col[7:0], row[7:0]}};
        if (recent_hits.size() > 64) void'(recent_hits.pop_front());
      end
    end else if (r.opcode == OP_READ) begin
      res.col = r.cell_x;
      res.row = r.cell_y;
      if (int'(r.cell_x) < GRID_W && int'(r.cell_y) < GRID_H) begin
        res.value = grid_img[int'(r.cell_y) * GRID_W + int'(r.cell_x)];
      end else begin
        res.value = UNKNOWN_COST;
      end
    end
    return res;
  endfunction

  function automatic fuse_req_t mk_cell(input logic [7:0] cx, input logic [7:0] cy,
                                        input logic [7:0] cost);
    fuse_req_t r;
    r = '0;
    r.opcode = OP_CELL;
    r.cell_x = cx;
    r.cell_y = cy;
    r.cost = cost;
    return r;
  endfunction

  function automatic fuse_req_t mk_read(input logic [7:0] cx, input logic [7:0] cy);
    fuse_req_t r;
    r = '0;
    r.opcode = OP_READ;
    r.cell_x = cx;
    r.cell_y = cy;
    return r;
  endfunction

  function automatic fuse_req_t mk_frame(input logic [31:0] rx, input logic [31:0] ry,
                                         input logic [15:0] c, input logic [15:0] s,
                                         input logic [31:0] ox, input logic [31:0] oy,
                                         input logic [23:0] cs);
    fuse_req_t r;
    r = '0;
    r.opcode = OP_FRAME;
    r.robot_x = rx;
    r.robot_y = ry;
    r.cos_yaw = c;
    r.sin_yaw = s;
    r.local_origin_x = ox;
    r.local_origin_y = oy;
    r.local_cell_size = cs;
    return r;
  endfunction

  function automatic void add_row(input fuse_req_t r, input logic typed, input fuse_res_t w);
    dir_row_t d;
    d.req = r;
    d.typed = typed;
    d.want = w;
    dir_rows = {dir_rows, d};
  endfunction

  function automatic fuse_req_t rand_req();
    fuse_req_t r;
    int unsigned pick;
    int unsigned k;
    real a;
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.opcode = OP_FRAME;
      if ($urandom_range(0, 3) != 0) begin
        r.robot_x = $urandom_range(131072, 1310720);
        r.robot_y = $urandom_range(131072, 1310720);
        a = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        r.cos_yaw = 16'($rtoi($cos(a) * 16384.0));
        r.sin_yaw = 16'($rtoi($sin(a) * 16384.0));
        r.local_origin_x = 32'(0 - $urandom_range(0, 393216));
        r.local_origin_y = 32'(0 - $urandom_range(0, 393216));
        r.local_cell_size = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(3277, 13107))
                                                        : CELL_SIZE_RST;
      end
    end else if (pick < 80) begin
      r.opcode = OP_CELL;
      r.cost = ($urandom_range(0, 9) == 0) ? UNKNOWN_COST : 8'($urandom_range(0, 254));
      if ($urandom_range(0, 9) < 4) begin
        r.cell_x = 8'($urandom_range(0, 15));
        r.cell_y = 8'($urandom_range(0, 15));
      end
    end else if (pick < 95) begin
      r.opcode = OP_READ;
      if (recent_hits.size() != 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, recent_hits.size() - 1);
        {r.cell_x, r.cell_y} = recent_hits[k];
      end
    end
    return r;
  endfunction

  task automatic send_req(input fuse_req_t r, input logic typed, input fuse_res_t want);
    fuse_res_t pred;
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.opcode;
    in_cell_x <= r.cell_x;
    in_cell_y <= r.cell_y;
    in_cost <= r.cost;
    in_robot_x <= r.robot_x;
    in_robot_y <= r.robot_y;
    in_cos_yaw <= r.cos_yaw;
    in_sin_yaw <= r.sin_yaw;
    in_local_origin_x <= r.local_origin_x;
    in_local_origin_y <= r.local_origin_y;
    in_local_cell_size <= r.local_cell_size;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = fuse_cell(r);
    if (typed) pending_entries = {pending_entries, want};
    else pending_entries = {pending_entries, pred};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      REG_GRID_ORIGIN_X: g_ox = $signed(val);
      REG_GRID_ORIGIN_Y: g_oy = $signed(val);
      REG_CELLS_PER_M:   g_cpm = longint'(val[23:0]);
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    int sent;
    fuse_req_t r;
    sent = 0;
    while (sent < n) begin
      r = rand_req();
      send_req(r, 1'b0, '0);
      if (r.opcode != OP_UNUSED) sent++;
    end
  endtask

  // receiver side: random stall, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_idle);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    fuse_res_t w;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected result value %0d col %0d row %0d", $time,
                 out_entry_value, out_grid_col, out_grid_row);
        mismatch_count++;
      end else begin
        w = pending_entries.pop_front();
        if (out_entry_value !== w.value) begin
          $display("%0t: entry_value expected %0d got %0d", $time, w.value, out_entry_value);
          mismatch_count++;
        end
        if (out_entry_updated !== w.updated) begin
          $display("%0t: entry_updated expected %0d got %0d", $time, w.updated,
                   out_entry_updated);
          mismatch_count++;
        end
        if (out_grid_col !== w.col) begin
          $display("%0t: grid_col expected %0d got %0d", $time, w.col, out_grid_col);
          mismatch_count++;
        end
        if (out_grid_row !== w.row) begin
          $display("%0t: grid_row expected %0d got %0d", $time, w.row, out_grid_row);
          mismatch_count++;
        end
      end
    end
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("costmap_to_grid_max_fusion_core verification failed");
      $finish;
    end
  end

  initial begin
    int m, k;
    logic [31:0] ox, oy, cpm;
    for (int i = 0; i < GRID_W * GRID_H; i++) grid_img[i] = UNKNOWN_COST;
    pose_x = 0;
    pose_y = 0;
    pose_c = POSE_COS_RST;
    pose_s = 0;
    fr_ox = 0;
    fr_oy = 0;
    fr_cs = longint'(CELL_SIZE_RST);
    g_ox = 0;
    g_oy = 0;
    g_cpm = longint'(CELLS_PER_M_RST);

    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_opcode <= '0;
    in_cell_x <= '0;
    in_cell_y <= '0;
    in_cost <= '0;
    in_robot_x <= '0;
    in_robot_y <= '0;
    in_cos_yaw <= '0;
    in_sin_yaw <= '0;
    in_local_origin_x <= '0;
    in_local_origin_y <= '0;
    in_local_cell_size <= '0;
    src_idle = 8;
    sink_idle = 52;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mk_read(8'd0, 8'd0), 1'b1, {UNKNOWN_COST, 1'b0, 8'd0, 8'd0});
    add_row(mk_read(8'd255, 8'd255), 1'b1, {UNKNOWN_COST, 1'b0, 8'd255, 8'd255});
    add_row(mk_cell(8'd0, 8'd0, UNKNOWN_COST), 1'b1, '0);
    add_row(mk_cell(8'd5, 8'd5, 8'd10), 1'b0, '0);
    add_row(mk_cell(8'd5, 8'd5, 8'd3), 1'b0, '0);
    add_row(mk_cell(8'd5, 8'd5, 8'd200), 1'b0, '0);
    add_row(mk_cell(8'd5, 8'd5, 8'd0), 1'b0, '0);
    add_row(mk_read(8'd5, 8'd5), 1'b0, '0);
    add_row(mk_cell(8'd255, 8'd255, 8'd0), 1'b0, '0);
    add_row(mk_cell(8'd0, 8'd0, 8'd254), 1'b0, '0);
    add_row({OP_UNUSED, 8'd1, 8'd2, 8'd3, 184'd0}, 1'b1, '0);
    add_row(mk_read(8'd0, 8'd0), 1'b0, '0);
    add_row(mk_frame(32'd838861, 32'd838861, 16'd0, 16'd16384, 32'd0, 32'd0, 24'd6554),
            1'b1, '0);
    add_row(mk_cell(8'd10, 8'd0, 8'd77), 1'b0, '0);
    add_row(mk_cell(8'd0, 8'd10, 8'd78), 1'b0, '0);
    add_row(mk_frame(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF), 1'b1, '0);
    add_row(mk_cell(8'd255, 8'd255, 8'd1), 1'b0, '0);
    add_row(mk_frame(32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
                     32'h80000000, 32'h80000000, 24'd0), 1'b1, '0);
    add_row(mk_cell(8'd0, 8'd0, 8'd2), 1'b0, '0);
    add_row(mk_cell(8'd200, 8'd100, 8'd3), 1'b0, '0);
    // half-turn: cells fold back from the robot
    add_row(mk_frame(32'd1638400, 32'd1638400, 16'hC000, 16'd0, 32'd0, 32'd0, 24'd6554),
            1'b1, '0);
    add_row(mk_cell(8'd3, 8'd4, 8'd150), 1'b0, '0);
    add_row(mk_read(8'd5, 8'd5), 1'b0, '0);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (m = 0; m < 3; m++) begin
      case (m)
        0: begin src_idle = 8; sink_idle = 52; end
        1: begin src_idle = 52; sink_idle = 8; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      for (k = 0; k < 2; k++) begin
        case (m * 2 + k)
          0: begin ox = 32'd0; oy = 32'd0; cpm = 32'(CELLS_PER_M_RST); end
          1: begin ox = 32'h80000000; oy = 32'h7FFFFFFF; cpm = 32'd1; end
          2: begin ox = 32'(-327680); oy = 32'(-327680); cpm = 32'd655360; end
          3: begin ox = 32'd0; oy = 32'd0; cpm = 32'hFFFFFF; end
          4: begin
            ox = 32'(0 - $urandom_range(0, 655360));
            oy = 32'(0 - $urandom_range(0, 655360));
            cpm = $urandom_range(65536, 2000000);
          end
          default: begin ox = 32'd131072; oy = 32'(-196608); cpm = 32'd1310720; end
        endcase
        apb_write(REG_GRID_ORIGIN_X, ox);
        apb_write(REG_GRID_ORIGIN_Y, oy);
        apb_write(REG_CELLS_PER_M, cpm);
        if (m == 2 && k == 0) hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        drain();
      end
    end

    if (mismatch_count == 0) begin
      $display("costmap_to_grid_max_fusion_core verification clean");
    end else begin
      $display("costmap_to_grid_max_fusion_core verification failed");
    end
    $finish;
  end

endmodule
